/* rtl/core/odo_pkg.sv */
// Shared types, constants and the CORDIC angle table for the planar odometry integrator.
// No dependencies; every other file of the block imports this package.
package odo_pkg;

  localparam int unsigned TRIG_ITERATIONS_DEF = 16;
  localparam int unsigned ATAN_ENTRIES = 24;
  localparam int unsigned ATAN_IDX_W = 5;

  localparam int unsigned POS_W   = 48;
  localparam int unsigned HEAD_W  = 32;
  localparam int unsigned CW      = 34;   // CORDIC x/y, Q2.30 plus headroom
  localparam int unsigned ZW      = 32;   // CORDIC residual angle
  localparam int unsigned CQW     = 22;   // sine/cosine rounded to Q20
  localparam int unsigned VDT_W   = 37;   // speed times time
  localparam int unsigned PROD_W  = 59;   // speed times time times Q20 trig
  localparam int unsigned DIV_NUM_W = 36;
  localparam int unsigned DIV_QE_W  = 22;
  localparam int unsigned DELTA_W   = 23;

  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [21:0] HEADING_SCALE = 22'd2799883;
  localparam logic [13:0] DIV_BASE      = 14'd15625;
  localparam int unsigned DIV_SHIFT     = 20;
  localparam logic [30:0] RECIP_BASE    = 31'd1125899906;
  localparam int unsigned RECIP_SHIFT   = 44;

  typedef struct packed {
    logic signed [15:0] forward_speed;
    logic signed [15:0] yaw_rate;
    logic [19:0]        elapsed_time;
  } odo_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position_x;
    logic signed [POS_W-1:0] position_y;
    logic [HEAD_W-1:0]       heading;
    logic signed [15:0]      quat_z;
    logic signed [15:0]      quat_w;
    logic signed [15:0]      speed_echo;
    logic signed [15:0]      yaw_rate_echo;
  } odo_out_t;

  typedef struct packed {
    logic load_in;
    logic cordic_init;
    logic cordic_half;
    logic cordic_step;
    logic trig_cap;
    logic head_upd;
    logic mul_cap;
    logic fin_load;
  } odo_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT_A,
    ST_TRIG,
    ST_MUL,
    ST_ROT_B,
    ST_FIN
  } odo_state_e;

  // atan(2^-i) as a fraction of a full turn, scaled by 2^32
  function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'd536870912;
      5'd1:    val = 32'd316933406;
      5'd2:    val = 32'd167458907;
      5'd3:    val = 32'd85004756;
      5'd4:    val = 32'd42667331;
      5'd5:    val = 32'd21354465;
      5'd6:    val = 32'd10679838;
      5'd7:    val = 32'd5340245;
      5'd8:    val = 32'd2670163;
      5'd9:    val = 32'd1335087;
      5'd10:   val = 32'd667544;
      5'd11:   val = 32'd333772;
      5'd12:   val = 32'd166886;
      5'd13:   val = 32'd83443;
      5'd14:   val = 32'd41722;
      5'd15:   val = 32'd20861;
      5'd16:   val = 32'd10430;
      5'd17:   val = 32'd5215;
      5'd18:   val = 32'd2608;
      5'd19:   val = 32'd1304;
      5'd20:   val = 32'd652;
      5'd21:   val = 32'd326;
      5'd22:   val = 32'd163;
      5'd23:   val = 32'd81;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

/* rtl/core/odo_cordic.sv */
// Iterative CORDIC rotator: one rotation per cycle while step_i is high, quarter-turn reduction on load.
// Depends on odo_pkg for widths, gain and the angle table.
module odo_cordic #(
  parameter int unsigned TrigIterations = odo_pkg::TRIG_ITERATIONS_DEF,
  localparam int unsigned IterW = $clog2(TrigIterations)
) (
  input  logic                          clk_i,
  input  logic                          init_i,
  input  logic                          step_i,
  input  logic [odo_pkg::HEAD_W-1:0]    angle_i,
  input  logic [IterW-1:0]              iter_i,
  output logic signed [odo_pkg::CW-1:0] cos_o,
  output logic signed [odo_pkg::CW-1:0] sin_o
);
  import odo_pkg::*;

  logic signed [CW-1:0] x_q, y_q, x_d, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic [1:0]           quad_q, quad_d;
  logic [HEAD_W-1:0]    ang_bias;
  logic signed [CW-1:0] x_sh, y_sh;
  logic signed [ZW-1:0] atan_s;

  assign ang_bias = angle_i + 32'h2000_0000;
  assign x_sh     = x_q >>> iter_i;
  assign y_sh     = y_q >>> iter_i;
  assign atan_s   = $signed(atan_turn(ATAN_IDX_W'(iter_i)));

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    quad_d = quad_q;
    if (init_i) begin
      quad_d = ang_bias[31:30];
      z_d    = $signed(angle_i - {ang_bias[31:30], 30'b0});
      x_d    = CORDIC_GAIN_Q30;
      y_d    = '0;
    end else if (step_i) begin
      if (!z_q[ZW-1]) begin
        x_d = x_q - y_sh;
        y_d = y_q + x_sh;
        z_d = z_q - atan_s;
      end else begin
        x_d = x_q + y_sh;
        y_d = y_q - x_sh;
        z_d = z_q + atan_s;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    quad_q <= quad_d;
  end

  always_comb begin
    case (quad_q)
      2'd0: begin
        cos_o = x_q;
        sin_o = y_q;
      end
      2'd1: begin
        cos_o = -y_q;
        sin_o = x_q;
      end
      2'd2: begin
        cos_o = -x_q;
        sin_o = -y_q;
      end
      default: begin
        cos_o = y_q;
        sin_o = -x_q;
      end
    endcase
  end

endmodule

/* rtl/core/odo_cdiv.sv */
// Free-running four-stage pipeline: signed divide by 15625 * 2^20, rounded half away from zero.
// Reciprocal multiply with one correction step; depends on odo_pkg for constants.
module odo_cdiv (
  input  logic                               clk_i,
  input  logic signed [odo_pkg::PROD_W-1:0]  num_i,
  output logic signed [odo_pkg::DELTA_W-1:0] quo_o
);
  import odo_pkg::*;

  localparam logic [PROD_W-1:0] DivHalf = PROD_W'(DIV_BASE) << (DIV_SHIFT - 1);
  localparam int unsigned RecipProdW = DIV_NUM_W + 31;

  logic [PROD_W-1:0]     mag, rnd;
  logic                  neg1_q, neg2_q, neg3_q;
  logic [DIV_NUM_W-1:0]  n1_q, n2_q, n3_q;
  logic [RecipProdW-1:0] recip_prod;
  logic [DIV_QE_W-1:0]   qe2_q, qe3_q, q_fix;
  logic [DIV_NUM_W-1:0]  qm3_q, rem;
  logic signed [DELTA_W-1:0] quo_q;

  assign mag        = num_i[PROD_W-1] ? PROD_W'(-num_i) : PROD_W'(num_i);
  assign rnd        = mag + DivHalf;
  assign recip_prod = RecipProdW'(n1_q) * RecipProdW'(RECIP_BASE);
  assign rem        = n3_q - qm3_q;
  assign q_fix      = qe3_q + DIV_QE_W'(rem >= DIV_NUM_W'(DIV_BASE));

  always_ff @(posedge clk_i) begin
    neg1_q <= num_i[PROD_W-1];
    n1_q   <= rnd[DIV_SHIFT +: DIV_NUM_W];
    neg2_q <= neg1_q;
    n2_q   <= n1_q;
    qe2_q  <= recip_prod[RECIP_SHIFT +: DIV_QE_W];
    neg3_q <= neg2_q;
    n3_q   <= n2_q;
    qe3_q  <= qe2_q;
    qm3_q  <= DIV_NUM_W'(DIV_NUM_W'(qe2_q) * DIV_NUM_W'(DIV_BASE));
    quo_q  <= neg3_q ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});
  end

  assign quo_o = quo_q;

endmodule

/* rtl/core/odo_datapath.sv */
// Datapath: input hold, products, heading and position accumulators, output register.
// Instantiates odo_cordic and odo_cdiv; driven by odo_ctrl commands; uses odo_pkg.
module odo_datapath #(
  parameter int unsigned TrigIterations = odo_pkg::TRIG_ITERATIONS_DEF,
  localparam int unsigned IterW = $clog2(TrigIterations)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  odo_pkg::odo_cmd_t cmd_i,
  input  logic [IterW-1:0]  iter_i,
  input  odo_pkg::odo_in_t  in_item_i,
  output odo_pkg::odo_out_t out_item_o
);
  import odo_pkg::*;

  localparam int unsigned HPW = 60;

  function automatic logic signed [CQW-1:0] round_q20(input logic signed [CW-1:0] v);
    logic [CW-1:0] m;
    logic [CW-1:0] s;
    logic signed [CQW-1:0] r;
    m = v[CW-1] ? CW'(-v) : CW'(v);
    s = m + CW'(512);
    r = s[10 +: CQW];
    return v[CW-1] ? -r : r;
  endfunction

  function automatic logic signed [15:0] round_q15(input logic signed [CW-1:0] v);
    logic [CW-1:0] m;
    logic [CW-1:0] s;
    logic [18:0]   r;
    logic [15:0]   o;
    m = v[CW-1] ? CW'(-v) : CW'(v);
    s = m + CW'(16384);
    r = s[15 +: 19];
    if (v[CW-1]) begin
      o = (r >= 19'd32768) ? 16'h8000 : -r[15:0];
    end else begin
      o = (r >= 19'd32768) ? 16'h7fff : r[15:0];
    end
    return $signed(o);
  endfunction

  function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] a,
                                                      input logic signed [DELTA_W-1:0] d);
    logic signed [POS_W:0] s;
    s = (POS_W+1)'(a) + (POS_W+1)'(d);
    if (s[POS_W] != s[POS_W-1]) begin
      return s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    return s[POS_W-1:0];
  endfunction

  odo_in_t                  in_q;
  logic signed [VDT_W-1:0]  v_ext, w_ext, dt_ext, vdt_q, wdt_q;
  logic signed [HPW-1:0]    hprod_q;
  logic [HPW-1:0]           hmag, hrnd;
  logic [HEAD_W-1:0]        dh_mag, dh_q;
  logic [HEAD_W-1:0]        heading_q;
  logic signed [POS_W-1:0]  pos_x_q, pos_y_q, pos_x_n, pos_y_n;
  logic signed [CQW-1:0]    c20_q, s20_q;
  logic signed [PROD_W-1:0] px_q, py_q;
  logic signed [DELTA_W-1:0] dx, dy;
  logic [HEAD_W-1:0]        cordic_ang;
  logic signed [CW-1:0]     cos_v, sin_v;
  odo_out_t                 out_q;

  assign v_ext  = VDT_W'(in_q.forward_speed);
  assign w_ext  = VDT_W'(in_q.yaw_rate);
  assign dt_ext = VDT_W'({1'b0, in_q.elapsed_time});

  assign hmag   = hprod_q[HPW-1] ? HPW'(-hprod_q) : HPW'(hprod_q);
  assign hrnd   = hmag + (HPW'(1) << 23);
  assign dh_mag = hrnd[24 +: HEAD_W];

  assign cordic_ang = cmd_i.cordic_half ? {1'b0, heading_q[HEAD_W-1:1]} : heading_q;

  odo_cordic #(
    .TrigIterations(TrigIterations)
  ) u_cordic (
    .clk_i  (clk_i),
    .init_i (cmd_i.cordic_init),
    .step_i (cmd_i.cordic_step),
    .angle_i(cordic_ang),
    .iter_i (iter_i),
    .cos_o  (cos_v),
    .sin_o  (sin_v)
  );

  odo_cdiv u_cdiv_x (
    .clk_i(clk_i),
    .num_i(px_q),
    .quo_o(dx)
  );

  odo_cdiv u_cdiv_y (
    .clk_i(clk_i),
    .num_i(py_q),
    .quo_o(dy)
  );

  assign pos_x_n = sat_add(pos_x_q, dx);
  assign pos_y_n = sat_add(pos_y_q, dy);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_item_i;
    end
    vdt_q   <= v_ext * dt_ext;
    wdt_q   <= w_ext * dt_ext;
    hprod_q <= HPW'(wdt_q) * HPW'($signed({1'b0, HEADING_SCALE}));
    dh_q    <= hprod_q[HPW-1] ? -dh_mag : dh_mag;
    if (cmd_i.trig_cap) begin
      c20_q <= round_q20(cos_v);
      s20_q <= round_q20(sin_v);
    end
    if (cmd_i.mul_cap) begin
      px_q <= PROD_W'(vdt_q) * PROD_W'(c20_q);
      py_q <= PROD_W'(vdt_q) * PROD_W'(s20_q);
    end
    if (cmd_i.fin_load) begin
      out_q.position_x    <= pos_x_n;
      out_q.position_y    <= pos_y_n;
      out_q.heading       <= heading_q;
      out_q.quat_z        <= round_q15(sin_v);
      out_q.quat_w        <= round_q15(cos_v);
      out_q.speed_echo    <= in_q.forward_speed;
      out_q.yaw_rate_echo <= in_q.yaw_rate;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q <= '0;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
    end else begin
      if (cmd_i.head_upd) begin
        heading_q <= heading_q + dh_q;
      end
      if (cmd_i.fin_load) begin
        pos_x_q <= pos_x_n;
        pos_y_q <= pos_y_n;
      end
    end
  end

  assign out_item_o = out_q;

`ifndef SYNTHESIS
  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.fin_load |=> $stable(pos_x_q) && $stable(pos_y_q))
    else $error("position accumulator moved without a result load");

  a_head_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.head_upd |=> $stable(heading_q))
    else $error("heading moved outside its update step");

  a_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_in |=> in_q == $past(in_item_i))
    else $error("input item not captured on load");
`endif

endmodule

/* rtl/core/odo_ctrl.sv */
// Controller: sequences the two CORDIC passes, products and result load; owns the handshakes.
// Depends on odo_pkg for the command struct and state enum.
module odo_ctrl #(
  parameter int unsigned TrigIterations = odo_pkg::TRIG_ITERATIONS_DEF,
  localparam int unsigned IterW = $clog2(TrigIterations)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output odo_pkg::odo_cmd_t cmd_o,
  output logic [IterW-1:0]  iter_o
);
  import odo_pkg::*;

  localparam logic [IterW-1:0] LastIter = IterW'(TrigIterations - 1);

  odo_state_e       state_q, state_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic             out_valid_q, out_valid_d;
  logic             accept, last, slot_free;
  odo_cmd_t         cmd;

  assign accept    = (state_q == ST_IDLE) && in_valid_i;
  assign last      = (iter_q == LastIter);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load_in     = 1'b1;
          cmd.cordic_init = 1'b1;
          state_d         = ST_ROT_A;
        end
      end
      ST_ROT_A: begin
        cmd.cordic_step = 1'b1;
        if (last) begin
          state_d = ST_TRIG;
        end
      end
      ST_TRIG: begin
        cmd.trig_cap = 1'b1;
        cmd.head_upd = 1'b1;
        state_d      = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_cap     = 1'b1;
        cmd.cordic_init = 1'b1;
        cmd.cordic_half = 1'b1;
        state_d         = ST_ROT_B;
      end
      ST_ROT_B: begin
        cmd.cordic_step = 1'b1;
        if (last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.fin_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    iter_d = (cmd.cordic_step && !last) ? iter_q + 1'b1 : '0;
    if (cmd.fin_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;
  assign iter_o      = iter_q;

`ifndef SYNTHESIS
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_ROT_A) && (iter_q == '0))
    else $error("item accepted without a fresh rotation pass");

  a_full_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TRIG || (state_q == ST_FIN && $past(state_q) != ST_FIN))
      |-> $past(iter_q) == LastIter)
    else $error("rotation pass ended early");

  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("result raised outside the final step");
`endif

endmodule

/* rtl/core/planar_odometry_integrator.sv */
// Top level of the planar odometry integrator: controller plus datapath.
// Depends on odo_pkg, odo_ctrl, odo_datapath (with odo_cordic and odo_cdiv).
//
//   channel | direction | handshake                 | payload
//   input   | in        | in_valid_i / in_ready_o   | in_item_i  (odo_in_t)
//   output  | out       | out_valid_o / out_ready_i | out_item_o (odo_out_t)
//
// After an item is accepted it runs the first CORDIC pass, the trig capture and heading update,
// the products and the second pass, then the final step that loads the output register; the next
// item is accepted only after that step, so items never overlap, paced by the shared CORDIC unit
// running two passes of one rotation per cycle.
// Input is ready whenever no item is in work; a finished result waits in the output register.
// If the previous result is still untaken, the next one holds in its final step until it is.
// Reset clears position and heading to zero; no clearing pass is needed.
module planar_odometry_integrator #(
  parameter int unsigned TrigIterations = odo_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  odo_pkg::odo_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output odo_pkg::odo_out_t out_item_o
);
  import odo_pkg::*;

  localparam int unsigned IterW = $clog2(TrigIterations);

  odo_cmd_t         cmd;
  logic [IterW-1:0] iter;

  odo_ctrl #(
    .TrigIterations(TrigIterations)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .iter_o     (iter)
  );

  odo_datapath #(
    .TrigIterations(TrigIterations)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .iter_i    (iter),
    .in_item_i (in_item_i),
    .out_item_o(out_item_o)
  );

endmodule
